FILE: rtl/skls_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the sorted-key lower-bound search.
// No dependencies; imported by every module of the block.
package skls_pkg;

  localparam int KEY_W  = 32;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 4;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [1:0] REG_KEY_COUNT = 2'd0;
  localparam logic [1:0] REG_FIRST_KEY = 2'd1;
  localparam logic [1:0] REG_LAST_KEY  = 2'd2;

  // control bits that travel with each transaction down the pipeline
  typedef struct packed {
    logic valid;
    logic search;
    logic done;
  } ctl_t;

endpackage

FILE: rtl/skls_front.sv
`timescale 1ns / 1ps
// Entry stage: registers a transaction and applies the first/last key checks.
// Depends on skls_pkg.
module skls_front import skls_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int IW = $clog2(TABLE_DEPTH),
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_cmd,
  input  logic [IW-1:0]    in_entry_index,
  input  logic [KEY_W-1:0] in_key_value,
  input  logic [CW-1:0]    n_keys,
  input  logic [KEY_W-1:0] first_key_value,
  input  logic [KEY_W-1:0] last_key_value,
  output ctl_t             out_ctl,
  output logic [CW-1:0]    out_lo,
  output logic [CW-1:0]    out_span,
  output logic [CW-1:0]    out_res,
  output logic [IW-1:0]    out_idx,
  output logic [KEY_W-1:0] out_key
);

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  ctl_t             ctl_r, ctl_nxt;
  logic [CW-1:0]    span_r, span_nxt;
  logic [CW-1:0]    res_r, res_nxt;
  logic [IW-1:0]    idx_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    n_eff;

  always_comb begin
    n_eff = (n_keys > DEPTH_C) ? DEPTH_C : n_keys;
    ctl_nxt.valid  = start;
    ctl_nxt.search = (in_cmd == CMD_SEARCH);
    ctl_nxt.done   = 1'b0;
    span_nxt       = n_eff;
    res_nxt        = '0;
    if (in_key_value <= first_key_value) begin
      ctl_nxt.done = 1'b1;
      res_nxt      = '0;
    end else if (in_key_value > last_key_value) begin
      ctl_nxt.done = 1'b1;
      res_nxt      = n_eff;
    end else if (n_eff <= CW'(1)) begin
      ctl_nxt.done = 1'b1;
      res_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
    res_r  <= res_nxt;
    idx_r  <= in_entry_index;
    key_r  <= in_key_value;
  end

  assign out_ctl  = ctl_r;
  assign out_lo   = '0;
  assign out_span = span_r;
  assign out_res  = res_r;
  assign out_idx  = idx_r;
  assign out_key  = key_r;

endmodule

FILE: rtl/skls_step.sv
`timescale 1ns / 1ps
// One halving step of the search with its own copy of the key table.
// Depends on skls_pkg; the table copy is written as a write transaction passes.
module skls_step import skls_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int IW = $clog2(TABLE_DEPTH),
  parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             in_ctl,
  input  logic [CW-1:0]    in_lo,
  input  logic [CW-1:0]    in_span,
  input  logic [CW-1:0]    in_res,
  input  logic [IW-1:0]    in_idx,
  input  logic [KEY_W-1:0] in_key,
  output ctl_t             out_ctl,
  output logic [CW-1:0]    out_lo,
  output logic [CW-1:0]    out_span,
  output logic [CW-1:0]    out_res,
  output logic [IW-1:0]    out_idx,
  output logic [KEY_W-1:0] out_key
);

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [KEY_W-1:0] mem [0:TABLE_DEPTH-1];

  ctl_t             ctl_r;
  logic [CW-1:0]    lo_r, span_r, res_r, mid_r;
  logic [IW-1:0]    idx_r;
  logic [KEY_W-1:0] key_r;
  logic [KEY_W-1:0] rd_r;
  logic [CW-1:0]    mid_nxt;
  logic             wr_en;
  logic [CW-1:0]    nxt;
  logic [CW-1:0]    lo_upd, span_upd;

  assign mid_nxt = in_lo + ((in_span - CW'(1)) >> 1);
  assign wr_en   = in_ctl.valid && (in_ctl.search == CMD_WRITE) &&
                   ({1'b0, in_idx} < DEPTH_C);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[in_idx] <= in_key;
    end
    rd_r <= mem[mid_nxt[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= in_lo;
    span_r <= in_span;
    res_r  <= in_res;
    mid_r  <= mid_nxt;
    idx_r  <= in_idx;
    key_r  <= in_key;
  end

  always_comb begin
    nxt      = mid_r + CW'(1);
    out_ctl  = ctl_r;
    out_lo   = lo_r;
    out_span = span_r;
    out_res  = res_r;
    lo_upd   = lo_r;
    span_upd = span_r;
    if (ctl_r.search && !ctl_r.done) begin
      if (rd_r == key_r) begin
        out_ctl.done = 1'b1;
        out_res      = mid_r;
      end else begin
        if (rd_r < key_r) begin
          lo_upd   = nxt;
          span_upd = span_r - (nxt - lo_r);
        end else begin
          span_upd = nxt - lo_r;
        end
        out_lo   = lo_upd;
        out_span = span_upd;
        if (span_upd <= CW'(1)) begin
          out_ctl.done = 1'b1;
          out_res      = lo_upd;
        end
      end
    end
  end

  assign out_idx = idx_r;
  assign out_key = key_r;

endmodule

FILE: rtl/sorted_key_lower_bound_search.sv
`timescale 1ns / 1ps
// Top level: register file, entry stage, chain of search steps, result register.
// Depends on skls_pkg, skls_front and skls_step.
//
// Fully pipelined: busy never rises, so a transaction is taken on every cycle that
// start is high. A search returns its found_index on out_valid after it passes
// one entry stage for the first/last key checks, one stage per halving step, each
// with its own table copy and one registered read, and the output register.
// out_valid is a one-cycle strobe and the receiver cannot hold results off.
// A write updates each table copy as it passes, so later searches always see it.
// Writes give no result. The user must write the registers only while no search
// is in flight; the block itself does not enforce this.
module sorted_key_lower_bound_search import skls_pkg::*; #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_cmd,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   in_entry_index,
  input  logic [KEY_W-1:0]                 in_key_value,
  output logic                             out_valid,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] out_found_index,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ADDR_W-1:0]                paddr,
  input  logic [DATA_W-1:0]                pwdata,
  output logic [DATA_W-1:0]                prdata,
  output logic                             pready
);

  localparam int IW      = $clog2(TABLE_DEPTH);
  localparam int CW      = $clog2(TABLE_DEPTH + 1);
  localparam int STEPS   = IW;
  localparam int LATENCY = STEPS + 2;

  logic [CW-1:0]    n_keys_r;
  logic [KEY_W-1:0] first_key_r;
  logic [KEY_W-1:0] last_key_r;
  logic             cfg_wr;
  logic [1:0]       reg_sel;

  ctl_t             c_ctl  [0:STEPS];
  logic [CW-1:0]    c_lo   [0:STEPS];
  logic [CW-1:0]    c_span [0:STEPS];
  logic [CW-1:0]    c_res  [0:STEPS];
  logic [IW-1:0]    c_idx  [0:STEPS];
  logic [KEY_W-1:0] c_key  [0:STEPS];

  logic             out_valid_r;
  logic [CW-1:0]    out_found_r;

  assign busy    = 1'b0;
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_keys_r    <= '0;
      first_key_r <= '0;
      last_key_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_KEY_COUNT: n_keys_r    <= pwdata[CW-1:0];
        REG_FIRST_KEY: first_key_r <= pwdata[KEY_W-1:0];
        REG_LAST_KEY:  last_key_r  <= pwdata[KEY_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_KEY_COUNT: prdata = DATA_W'(n_keys_r);
      REG_FIRST_KEY: prdata = DATA_W'(first_key_r);
      REG_LAST_KEY:  prdata = DATA_W'(last_key_r);
      default:       prdata = '0;
    endcase
  end

  skls_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IW(IW),
    .CW(CW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start && !busy),
    .in_cmd         (in_cmd),
    .in_entry_index (in_entry_index),
    .in_key_value   (in_key_value),
    .n_keys         (n_keys_r),
    .first_key_value(first_key_r),
    .last_key_value (last_key_r),
    .out_ctl        (c_ctl[0]),
    .out_lo         (c_lo[0]),
    .out_span       (c_span[0]),
    .out_res        (c_res[0]),
    .out_idx        (c_idx[0]),
    .out_key        (c_key[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    skls_step #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .IW(IW),
      .CW(CW)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_ctl  (c_ctl[g]),
      .in_lo   (c_lo[g]),
      .in_span (c_span[g]),
      .in_res  (c_res[g]),
      .in_idx  (c_idx[g]),
      .in_key  (c_key[g]),
      .out_ctl (c_ctl[g+1]),
      .out_lo  (c_lo[g+1]),
      .out_span(c_span[g+1]),
      .out_res (c_res[g+1]),
      .out_idx (c_idx[g+1]),
      .out_key (c_key[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= c_ctl[STEPS].valid && c_ctl[STEPS].search;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= c_res[STEPS];
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = out_found_r;

`ifndef SYNTHESIS
  a_search_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_SEARCH) |-> ##LATENCY out_valid)
    else $error("search transaction gave no result");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_WRITE) |-> ##LATENCY !out_valid)
    else $error("write transaction gave a result");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found_index <= CW'(TABLE_DEPTH)))
    else $error("found_index beyond table depth");

  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (c_ctl[STEPS].valid && c_ctl[STEPS].search) |-> c_ctl[STEPS].done)
    else $error("search left the pipeline unresolved");
`endif

endmodule
